### design/baa_pkg.sv
// Shared types, constants and helpers for the bump arena allocator.
// No dependencies.
package baa_pkg;

  localparam int MaxArenaBytes = 65536;
  localparam int HeaderBytes   = 32;
  localparam int SlotBytes     = 16;
  localparam int SlotCount     = (MaxArenaBytes + SlotBytes - 1) / SlotBytes;
  localparam int SlotIdxW      = $clog2(SlotCount);
  localparam int GenW          = 16;
  localparam int SizeW         = 17;
  localparam int HdrW          = GenW + SizeW;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_REALLOC = 2'd1,
    FUNC_RESET   = 2'd2,
    FUNC_REINIT  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_BAD_BLOCK = 3'd3,
    ST_NO_BUFFER = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_ALIGN = 2'd0,
    REG_CAP   = 2'd1,
    REG_ZFILL = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic              we;
    logic [SlotIdxW-1:0] waddr;
    logic [HdrW-1:0]   wdata;
    logic              re;
    logic [SlotIdxW-1:0] raddr;
  } hdr_req_t;

endpackage

### design/baa_hdr_ram.sv
// Header store: one entry per slot, generation and payload size.
// Depends on baa_pkg.
module baa_hdr_ram
  import baa_pkg::*;
(
  input  logic            clk,
  input  hdr_req_t        req,
  output logic [HdrW-1:0] rdata
);

  logic [HdrW-1:0] mem [SlotCount];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### design/bump_arena_allocator_unit.sv
// Bump arena allocator top level: config registers, sequencer, header store.
// Depends on baa_pkg and baa_hdr_ram.
//
// After reset the block sweeps all 4096 header slots (one slot a cycle) and
// takes no item until done. The slot entry is read from the header store at
// the accepting edge; the following cycle checks it and writes the header
// back, and the result is then offered from an output register until taken.
// The block takes no new item while a result is pending; the next item is
// accepted from the cycle after the result transfer.
// APB reads return the registers.
module bump_arena_allocator_unit
  import baa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_old_payload_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_offset,
  output logic        out_moved,
  output logic [16:0] out_copy_length,
  output logic [15:0] out_zero_start,
  output logic [16:0] out_zero_length,
  output logic [16:0] out_used_bytes,
  output logic [16:0] out_peak_since_reset,
  output logic [16:0] out_peak_lifetime,
  output logic [31:0] out_alloc_total,
  output logic [31:0] out_realloc_total
);

  // configuration
  logic [7:0]  align_r;
  logic [16:0] cap_r;
  logic        zfill_r;
  logic [1:0]  reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= 8'd16;
      cap_r   <= 17'd65536;
      zfill_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx_t'(reg_sel))
        REG_ALIGN: align_r <= cfg_pwdata[7:0];
        REG_CAP:   cap_r   <= cfg_pwdata[16:0];
        REG_ZFILL: zfill_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(reg_sel))
      REG_ALIGN: cfg_prdata = {24'd0, align_r};
      REG_CAP:   cfg_prdata = {15'd0, cap_r};
      REG_ZFILL: cfg_prdata = {31'd0, zfill_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // state
  fsm_t         state_r, state_nxt;
  logic [SlotIdxW-1:0] clr_r, clr_nxt;
  logic [16:0]  bump_r, bump_nxt;
  logic         lbv_r, lbv_nxt;
  logic [15:0]  lbo_r, lbo_nxt;
  logic [16:0]  lbs_r, lbs_nxt;
  logic [15:0]  gen_r, gen_nxt;
  logic [16:0]  pkr_r, pkr_nxt;
  logic [16:0]  pkl_r, pkl_nxt;
  logic [31:0]  acnt_r, acnt_nxt;
  logic [31:0]  rcnt_r, rcnt_nxt;
  logic [1:0]   func_r;
  logic [16:0]  size_r;
  logic [15:0]  old_r;

  logic [2:0]   st_r, st_nxt;
  logic [15:0]  res_r, res_nxt;
  logic         mv_r, mv_nxt;
  logic [16:0]  cp_r, cp_nxt;
  logic [15:0]  zs_r, zs_nxt;
  logic [16:0]  zl_r, zl_nxt;

  hdr_req_t        hreq;
  logic [HdrW-1:0] hrd;

  baa_hdr_ram u_ram (
    .clk   (clk),
    .req   (hreq),
    .rdata (hrd)
  );

  // derived configuration
  logic [7:0]  amask;
  logic [16:0] cap_e;
  logic        pow2;

  assign pow2  = (align_r >= 8'd16) && (align_r <= 8'd128) &&
                 ((align_r & (align_r - 8'd1)) == 8'd0);
  assign amask = pow2 ? (align_r - 8'd1) : 8'd15;
  assign cap_e = (cap_r > 17'(MaxArenaBytes)) ? 17'(MaxArenaBytes) : cap_r;

  function automatic logic [18:0] rnd(input logic [18:0] v, input logic [7:0] m);
    logic [18:0] s;
    s   = v + {11'd0, m};
    rnd = s & ~{11'd0, m};
  endfunction

  // alloc candidate from current bump pointer
  logic [18:0] a_p, a_next, a_hoff;
  logic        a_ok;
  assign a_p    = rnd({2'd0, bump_r} + 19'(HeaderBytes), amask);
  assign a_next = rnd(a_p + {2'd0, size_r}, amask);
  assign a_hoff = a_p - 19'(HeaderBytes);
  assign a_ok   = (a_next <= {2'd0, cap_e}) && (a_hoff <= {2'd0, bump_r});

  // realloc checks
  logic [16:0] r_hoff;
  logic        r_bad;
  logic [15:0] h_gen;
  logic [16:0] h_sz;
  logic [18:0] r_tail, r_next;
  logic        r_last;

  assign r_hoff = {1'b0, old_r} - 17'(HeaderBytes);
  assign h_gen  = hrd[HdrW-1:SizeW];
  assign h_sz   = hrd[SizeW-1:0];
  assign r_bad  = ({1'b0, old_r} >= cap_e) || (old_r < 16'(HeaderBytes)) ||
                  (r_hoff > bump_r) || (old_r[3:0] != 4'd0) || (h_gen != gen_r);
  assign r_tail = rnd({3'd0, old_r} + {2'd0, h_sz}, amask);
  assign r_next = rnd({3'd0, old_r} + {2'd0, size_r}, amask);
  assign r_last = lbv_r && (old_r == lbo_r) && (h_sz == lbs_r) &&
                  ({2'd0, bump_r} == r_tail);

  function automatic logic [31:0] sinc(input logic [31:0] v);
    sinc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [16:0] pmax(input logic [16:0] p, input logic [16:0] n);
    pmax = (n > p) ? n : p;
  endfunction

  logic [16:0] cpy;
  assign cpy = (h_sz < size_r) ? h_sz : size_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    bump_nxt  = bump_r;
    lbv_nxt   = lbv_r;
    lbo_nxt   = lbo_r;
    lbs_nxt   = lbs_r;
    gen_nxt   = gen_r;
    pkr_nxt   = pkr_r;
    pkl_nxt   = pkl_r;
    acnt_nxt  = acnt_r;
    rcnt_nxt  = rcnt_r;
    st_nxt    = st_r;
    res_nxt   = res_r;
    mv_nxt    = mv_r;
    cp_nxt    = cp_r;
    zs_nxt    = zs_r;
    zl_nxt    = zl_r;
    hreq      = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        hreq.we    = 1'b1;
        hreq.waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        hreq.re    = 1'b1;
        hreq.raddr = SlotIdxW'((in_old_payload_offset - 16'(HeaderBytes)) >> 4);
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        st_nxt = ST_OK;
        res_nxt = '0;
        mv_nxt = 1'b0;
        cp_nxt = '0;
        zs_nxt = '0;
        zl_nxt = '0;
        if (func_t'(func_r) == FUNC_RESET || func_t'(func_r) == FUNC_REINIT) begin
          bump_nxt = '0;
          lbv_nxt  = 1'b0;
          lbo_nxt  = '0;
          lbs_nxt  = '0;
          pkr_nxt  = '0;
          if (func_t'(func_r) == FUNC_REINIT) begin
            pkl_nxt  = '0;
            acnt_nxt = '0;
            rcnt_nxt = '0;
            gen_nxt  = (gen_r == 16'hFFFF) ? 16'd1 : gen_r + 16'd1;
          end
        end else if (cap_e == 17'd0) begin
          st_nxt = ST_NO_BUFFER;
        end else if (size_r == 17'd0) begin
          st_nxt = ST_ZERO_SIZE;
        end else if (func_t'(func_r) == FUNC_REALLOC && r_bad) begin
          st_nxt = ST_BAD_BLOCK;
        end else if (func_t'(func_r) == FUNC_REALLOC && r_last) begin
          if (r_next > {2'd0, cap_e}) begin
            st_nxt = ST_NO_SPACE;
          end else begin
            hreq.we    = 1'b1;
            hreq.waddr = SlotIdxW'(r_hoff >> 4);
            hreq.wdata = {gen_r, size_r};
            lbs_nxt    = size_r;
            rcnt_nxt   = sinc(rcnt_r);
            bump_nxt   = r_next[16:0];
            pkr_nxt    = pmax(pkr_r, r_next[16:0]);
            pkl_nxt    = pmax(pkl_r, r_next[16:0]);
            res_nxt    = old_r;
            if (zfill_r && size_r > h_sz) begin
              zs_nxt = 16'(old_r + h_sz[15:0]);
              zl_nxt = size_r - h_sz;
            end
          end
        end else if (!a_ok) begin
          st_nxt = ST_NO_SPACE;
        end else begin
          hreq.we    = 1'b1;
          hreq.waddr = SlotIdxW'(a_hoff >> 4);
          hreq.wdata = {gen_r, size_r};
          lbv_nxt    = 1'b1;
          lbo_nxt    = a_p[15:0];
          lbs_nxt    = size_r;
          acnt_nxt   = sinc(acnt_r);
          bump_nxt   = a_next[16:0];
          pkr_nxt    = pmax(pkr_r, a_next[16:0]);
          pkl_nxt    = pmax(pkl_r, a_next[16:0]);
          res_nxt    = a_p[15:0];
          if (func_t'(func_r) == FUNC_REALLOC) begin
            rcnt_nxt = sinc(rcnt_r);
            mv_nxt   = 1'b1;
            cp_nxt   = cpy;
            if (zfill_r && size_r > cpy) begin
              zs_nxt = 16'(a_p[15:0] + cpy[15:0]);
              zl_nxt = size_r - cpy;
            end
          end else if (zfill_r) begin
            zs_nxt = a_p[15:0];
            zl_nxt = size_r;
          end
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      bump_r  <= '0;
      lbv_r   <= 1'b0;
      lbo_r   <= '0;
      lbs_r   <= '0;
      gen_r   <= 16'd1;
      pkr_r   <= '0;
      pkl_r   <= '0;
      acnt_r  <= '0;
      rcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      bump_r  <= bump_nxt;
      lbv_r   <= lbv_nxt;
      lbo_r   <= lbo_nxt;
      lbs_r   <= lbs_nxt;
      gen_r   <= gen_nxt;
      pkr_r   <= pkr_nxt;
      pkl_r   <= pkl_nxt;
      acnt_r  <= acnt_nxt;
      rcnt_r  <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      size_r <= in_request_size;
      old_r  <= in_old_payload_offset;
    end
    st_r  <= st_nxt;
    res_r <= res_nxt;
    mv_r  <= mv_nxt;
    cp_r  <= cp_nxt;
    zs_r  <= zs_nxt;
    zl_r  <= zl_nxt;
  end

  assign out_status           = st_r;
  assign out_result_offset    = res_r;
  assign out_moved            = mv_r;
  assign out_copy_length      = cp_r;
  assign out_zero_start       = zs_r;
  assign out_zero_length      = zl_r;
  assign out_used_bytes       = bump_r;
  assign out_peak_since_reset = pkr_r;
  assign out_peak_lifetime    = pkl_r;
  assign out_alloc_total      = acnt_r;
  assign out_realloc_total    = rcnt_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (pkr_r >= bump_r) && (pkl_r >= pkr_r)) else $error("peak below bump pointer");
  a_gen: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != 16'd0) else $error("generation zero");
  a_bump_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (bump_r <= 17'd65536)) else $error("bump past arena");

endmodule

### bench/bump_arena_allocator_unit_tb.sv
// Self-checking testbench for bump_arena_allocator_unit: random and directed
// alloc/realloc/reset/reinit items against a behavioral arena predictor.
// Depends on baa_pkg and the design sources.
`timescale 1ns / 1ps

module bump_arena_allocator_unit_tb;
  import baa_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] offset;
    logic        moved;
    logic [16:0] copy_len;
    logic [15:0] zstart;
    logic [16:0] zlen;
    logic [16:0] used;
    logic [16:0] peak_rst;
    logic [16:0] peak_life;
    logic [31:0] allocs;
    logic [31:0] reallocs;
  } alloc_result_t;

  class arena_scoreboard;
    int unsigned align_reg, cap_reg, zfill_reg;
    int unsigned bump, last_off, last_blk_sz, gen_now, peak_rst, peak_life;
    int unsigned allocs, reallocs;
    bit          last_valid;
    int unsigned slot_size[SlotCount];
    int unsigned slot_gen[SlotCount];
    alloc_result_t pending[$];
    int          errors;

    function new();
      align_reg = 16; cap_reg = 65536; zfill_reg = 0;
      bump = 0; last_valid = 0; last_off = 0; last_blk_sz = 0; gen_now = 1;
      peak_rst = 0; peak_life = 0; allocs = 0; reallocs = 0; errors = 0;
      foreach (slot_size[i]) begin
        slot_size[i] = 0;
        slot_gen[i] = 0;
      end
    endfunction

    function int unsigned align_eff();
      int unsigned a;
      a = align_reg;
      if (a < 16 || a > 128 || (a & (a - 1)) != 0) a = 16;
      return a;
    endfunction

    function int unsigned cap_eff();
      return cap_reg > MaxArenaBytes ? MaxArenaBytes : cap_reg;
    endfunction

    function int unsigned rup(int unsigned v, int unsigned a);
      return (v + a - 1) & ~(a - 1);
    endfunction

    function int unsigned sat(int unsigned v);
      return v == 32'hFFFF_FFFF ? v : v + 1;
    endfunction

    function void bump_to(int unsigned nxt);
      bump = nxt;
      if (nxt > peak_rst) peak_rst = nxt;
      if (nxt > peak_life) peak_life = nxt;
    endfunction

    function bit place_block(int unsigned sz, output int unsigned pay);
      int unsigned a, p, nxt, hoff;
      a = align_eff();
      p = rup(bump + HeaderBytes, a);
      nxt = rup(p + sz, a);
      hoff = p - HeaderBytes;
      pay = 0;
      if (nxt > cap_eff() || hoff > bump || hoff / SlotBytes >= SlotCount) return 0;
      slot_size[hoff / SlotBytes] = sz;
      slot_gen[hoff / SlotBytes] = gen_now;
      last_valid = 1; last_off = p; last_blk_sz = sz;
      allocs = sat(allocs);
      bump_to(nxt);
      pay = p;
      return 1;
    endfunction

    function void clear_arena();
      bump = 0; last_valid = 0; last_off = 0; last_blk_sz = 0; peak_rst = 0;
    endfunction

    function void note_input(func_t f, int unsigned sz, int unsigned old);
      alloc_result_t r;
      int unsigned p, hoff, idx, osz, cp;
      r = '{default: 0};
      r.status = ST_OK;
      if (f == FUNC_RESET) clear_arena();
      else if (f == FUNC_REINIT) begin
        clear_arena();
        peak_life = 0; allocs = 0; reallocs = 0;
        gen_now = gen_now == 65535 ? 1 : gen_now + 1;
      end else if (cap_eff() == 0) r.status = ST_NO_BUFFER;
      else if (sz == 0) r.status = ST_ZERO_SIZE;
      else if (f == FUNC_ALLOC) begin
        if (!place_block(sz, p)) r.status = ST_NO_SPACE;
        else begin
          r.offset = 16'(p);
          if (zfill_reg) begin
            r.zstart = 16'(p);
            r.zlen = 17'(sz);
          end
        end
      end else begin
        hoff = old - HeaderBytes;
        idx = hoff / SlotBytes;
        if (old >= cap_eff() || old < HeaderBytes || hoff > bump || old % SlotBytes != 0
            || idx >= SlotCount || slot_gen[idx] != gen_now) r.status = ST_BAD_BLOCK;
        else begin
          osz = slot_size[idx];
          if (last_valid && old == last_off && osz == last_blk_sz
              && bump == rup(old + osz, align_eff())) begin
            p = rup(old + sz, align_eff());
            if (p > cap_eff()) r.status = ST_NO_SPACE;
            else begin
              slot_size[idx] = sz;
              last_blk_sz = sz;
              reallocs = sat(reallocs);
              bump_to(p);
              r.offset = 16'(old);
              if (zfill_reg && sz > osz) begin
                r.zstart = 16'(old + osz);
                r.zlen = 17'(sz - osz);
              end
            end
          end else if (!place_block(sz, p)) r.status = ST_NO_SPACE;
          else begin
            reallocs = sat(reallocs);
            cp = osz < sz ? osz : sz;
            r.offset = 16'(p); r.moved = 1; r.copy_len = 17'(cp);
            if (zfill_reg && sz > cp) begin
              r.zstart = 16'(p + cp);
              r.zlen = 17'(sz - cp);
            end
          end
        end
      end
      r.used = 17'(bump); r.peak_rst = 17'(peak_rst); r.peak_life = 17'(peak_life);
      r.allocs = allocs; r.reallocs = reallocs;
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $realtime, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got != e) begin
        $display({"%0t: mismatch exp st=%0d off=%0d mv=%0d cp=%0d zs=%0d zl=%0d",
                  " used=%0d pr=%0d pl=%0d a=%0d r=%0d"},
                 $realtime, e.status, e.offset, e.moved, e.copy_len, e.zstart, e.zlen,
                 e.used, e.peak_rst, e.peak_life, e.allocs, e.reallocs);
        $display({"%0t: mismatch act st=%0d off=%0d mv=%0d cp=%0d zs=%0d zl=%0d",
                  " used=%0d pr=%0d pl=%0d a=%0d r=%0d"},
                 $realtime, got.status, got.offset, got.moved, got.copy_len, got.zstart,
                 got.zlen, got.used, got.peak_rst, got.peak_life, got.allocs, got.reallocs);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  logic        in_valid, in_ready;
  logic [1:0]  in_func;
  logic [16:0] in_request_size;
  logic [15:0] in_old_payload_offset;
  logic        out_valid, out_ready;
  logic [2:0]  out_status;
  logic [15:0] out_result_offset;
  logic        out_moved;
  logic [16:0] out_copy_length;
  logic [15:0] out_zero_start;
  logic [16:0] out_zero_length;
  logic [16:0] out_used_bytes, out_peak_since_reset, out_peak_lifetime;
  logic [31:0] out_alloc_total, out_realloc_total;

  arena_scoreboard sb;
  bit          quiet_tail;
  int unsigned stall_cycles;
  int unsigned live_offsets[$];

  bump_arena_allocator_unit i_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // out_ready with random stall bursts
  initial begin
    int burst;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_status, out_result_offset, out_moved, out_copy_length,
                        out_zero_start, out_zero_length, out_used_bytes,
                        out_peak_since_reset, out_peak_lifetime, out_alloc_total,
                        out_realloc_total});
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_psel && cfg_penable)) stall_cycles <= 0;
    else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 4'(r) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (r)
      REG_ALIGN: sb.align_reg = v & 32'hFF;
      REG_CAP:   sb.cap_reg = v & 32'h1FFFF;
      default:   sb.zfill_reg = v & 1;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(func_t f, int unsigned sz, int unsigned old);
    int burst;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (burst) @(posedge clk);
    end
    in_valid <= 1; in_func <= f; in_request_size <= 17'(sz);
    in_old_payload_offset <= 16'(old);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(f, sz, old);
    if (f == FUNC_ALLOC || f == FUNC_REALLOC) begin
      if (sb.pending[$].status == ST_OK) live_offsets.push_back(sb.pending[$].offset);
    end else live_offsets = {};
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 131071);
      1:       return 0;
      2, 3:    return $urandom_range(1, 4096);
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  function automatic int unsigned pick_old();
    int n;
    n = live_offsets.size();
    if (n > 0 && $urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1)) return live_offsets[n - 1];
      return live_offsets[$urandom_range(0, n - 1)];
    end
    if ($urandom_range(0, 1)) return $urandom_range(0, 65535);
    return $urandom_range(0, 200) * 16;
  endfunction

  task automatic random_phase(int count);
    int unsigned k;
    repeat (count) begin
      k = $urandom_range(0, 99);
      if (k < 45) send_item(FUNC_ALLOC, pick_size(), $urandom_range(0, 65535));
      else if (k < 90) send_item(FUNC_REALLOC, pick_size(), pick_old());
      else if (k < 97) send_item(FUNC_RESET, $urandom_range(0, 131071),
                                 $urandom_range(0, 65535));
      else send_item(FUNC_REINIT, $urandom_range(0, 131071), $urandom_range(0, 65535));
    end
  endtask

  initial begin
    int unsigned caps[5];
    int unsigned aligns[5];
    caps = '{65536, 1024, 4096, 131071, 300};
    aligns = '{16, 128, 32, 64, 255};
    sb = new();
    quiet_tail = 0;
    rst_n = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    in_valid = 0; in_func = FUNC_ALLOC; in_request_size = 0; in_old_payload_offset = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    send_item(FUNC_ALLOC, 0, 0);
    send_item(FUNC_ALLOC, 1, 0);
    send_item(FUNC_REALLOC, 100, 48);
    send_item(FUNC_REALLOC, 10, 48);
    send_item(FUNC_ALLOC, 200, 0);
    send_item(FUNC_REALLOC, 500, 48);
    send_item(FUNC_REALLOC, 5, 40);
    send_item(FUNC_REALLOC, 5, 16);
    send_item(FUNC_REALLOC, 5, 65535);
    send_item(FUNC_REALLOC, 5, 4000);
    send_item(FUNC_ALLOC, 131071, 0);
    send_item(FUNC_ALLOC, 65536, 0);
    send_item(FUNC_RESET, 0, 0);
    send_item(FUNC_REALLOC, 50, 48);
    send_item(FUNC_REINIT, 0, 0);
    send_item(FUNC_REALLOC, 50, 48);
    send_item(FUNC_ALLOC, 65504, 0);
    send_item(FUNC_REALLOC, 65505, 32);
    drain();
    write_reg(REG_ZFILL, 1);
    write_reg(REG_CAP, 0);
    send_item(FUNC_ALLOC, 10, 0);
    send_item(FUNC_REALLOC, 0, 48);
    send_item(FUNC_RESET, 0, 0);
    drain();
    write_reg(REG_CAP, 65536);
    send_item(FUNC_ALLOC, 40, 0);
    send_item(FUNC_ALLOC, 40, 0);
    send_item(FUNC_REALLOC, 90, 32);
    send_item(FUNC_REALLOC, 20, 112);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_ALIGN, aligns[ph]);
      write_reg(REG_CAP, caps[ph]);
      write_reg(REG_ZFILL, ph % 2);
      random_phase(ph == 4 ? 80 : 110);
    end
    drain();
    quiet_tail = 1;
    write_reg(REG_ALIGN, 16);
    write_reg(REG_CAP, 65536);
    random_phase(70);
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
